[sv/ialu_pkg.sv]
package ialu_pkg;

  localparam int XLEN        = 32;
  localparam int REG_IDX_W   = 5;
  localparam int MODE_W      = 5;
  localparam int SHAMT_W     = 5;
  localparam int UPPER_SHIFT = 12;

  typedef logic [XLEN-1:0]      word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 5'd0,
    MODE_SUB   = 5'd1,
    MODE_SLL   = 5'd2,
    MODE_SLT   = 5'd3,
    MODE_SLTU  = 5'd4,
    MODE_XOR   = 5'd5,
    MODE_SRL   = 5'd6,
    MODE_SRA   = 5'd7,
    MODE_OR    = 5'd8,
    MODE_AND   = 5'd9,
    MODE_ADDI  = 5'd10,
    MODE_SLTI  = 5'd11,
    MODE_SLTIU = 5'd12,
    MODE_XORI  = 5'd13,
    MODE_ORI   = 5'd14,
    MODE_ANDI  = 5'd15,
    MODE_SLLI  = 5'd16,
    MODE_SRLI  = 5'd17,
    MODE_SRAI  = 5'd18,
    MODE_LUI   = 5'd19,
    MODE_AUIPC = 5'd20,
    MODE_BEQ   = 5'd21,
    MODE_BNE   = 5'd22,
    MODE_BLT   = 5'd23,
    MODE_BGE   = 5'd24,
    MODE_BLTU  = 5'd25,
    MODE_BGEU  = 5'd26
  } mode_t;

endpackage

[sv/ialu_if.sv]
interface ialu_in_if;
  import ialu_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  reg_idx_t            dest_index;
  reg_idx_t            src_a_index;
  reg_idx_t            src_b_index;
  word_t               immediate;

  modport source (output valid, mode, dest_index, src_a_index, src_b_index, immediate,
                  input ready);
  modport sink   (input valid, mode, dest_index, src_a_index, src_b_index, immediate,
                  output ready);
endinterface

interface ialu_out_if;
  import ialu_pkg::*;

  logic     valid;
  logic     ready;
  logic     write_enable;
  reg_idx_t write_index;
  word_t    write_value;
  logic     branch_taken;
  word_t    next_pc;

  modport source (output valid, write_enable, write_index, write_value, branch_taken, next_pc,
                  input ready);
  modport sink   (input valid, write_enable, write_index, write_value, branch_taken, next_pc,
                  output ready);
endinterface

[sv/integer_alu_and_branch_execute.sv]
// Channel  Dir     Handshake    Payload
// in_ch    sink    valid/ready  mode, dest_index, src_a_index, src_b_index, immediate
// out_ch   source  valid/ready  write_enable, write_index, write_value, branch_taken, next_pc
//
// The accepting edge reads both operands from the register file into the input register.
// The item then executes from the input register; the edge on which it moves on writes the
// register file, the program counter and the result register together, so the result is
// offered from the result register. One item is accepted every cycle while out_ch drains.
// Reset (rst_n low, synchronous) clears the register valid bits, the program counter and
// both stage valids; a register never written since reset reads as zero.
// A stalled out_ch holds the result register and the input register; in_ch stays ready
// while the input register is empty or moves forward in the same cycle.
module integer_alu_and_branch_execute #(
  parameter int NUM_REGS = 32
) (
  input  logic clk,
  input  logic rst_n,
  ialu_in_if.sink    in_ch,
  ialu_out_if.source out_ch
);
  import ialu_pkg::*;

  localparam int IDX_W = $clog2(NUM_REGS);

  // Register file storage. Entries carry a valid bit so that reset reads as all zeros
  // without a clearing pass; register zero is never written and always reads as zero.
  word_t                regs [NUM_REGS];
  logic  [NUM_REGS-1:0] reg_valid_r;

  word_t pc_r;

  // Input (operand) stage.
  logic              s1_valid_r;
  logic [MODE_W-1:0] s1_mode_r;
  reg_idx_t          s1_dest_r;
  word_t             s1_imm_r;
  word_t             s1_rdata_a_r;
  word_t             s1_rdata_b_r;
  logic              s1_zero_a_r;
  logic              s1_zero_b_r;
  logic              s1_fwd_a_r;
  logic              s1_fwd_b_r;

  // Result of the last item executed, used when an operand was read in the same
  // cycle that the item ahead of it wrote that register.
  word_t wb_val_r;

  // Result stage.
  logic     out_valid_r;
  logic     out_we_r;
  reg_idx_t out_idx_r;
  word_t    out_val_r;
  logic     out_taken_r;
  word_t    out_pc_r;

  logic in_fire;
  logic exe_fire;

  logic  src_a_ok;
  logic  src_b_ok;
  logic  zero_a_nxt;
  logic  zero_b_nxt;
  logic  fwd_a_nxt;
  logic  fwd_b_nxt;

  word_t                  opa;
  word_t                  opb;
  logic  [SHAMT_W-1:0]    shamt_b;
  logic  [SHAMT_W-1:0]    shamt_i;
  word_t                  upper_imm;
  logic                   lt_s_ab;
  logic                   lt_u_ab;
  word_t                  exe_val;
  logic                   exe_alu;
  logic                   exe_cond;
  logic                   exe_we;
  word_t                  pc_nxt;

  assign exe_fire    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || exe_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Operand read decisions made at acceptance time.
  assign src_a_ok = ({1'b0, in_ch.src_a_index} < (REG_IDX_W+1)'(NUM_REGS))
                    && (in_ch.src_a_index != '0);
  assign src_b_ok = ({1'b0, in_ch.src_b_index} < (REG_IDX_W+1)'(NUM_REGS))
                    && (in_ch.src_b_index != '0);

  assign fwd_a_nxt  = exe_fire && exe_we && (s1_dest_r == in_ch.src_a_index);
  assign fwd_b_nxt  = exe_fire && exe_we && (s1_dest_r == in_ch.src_b_index);
  assign zero_a_nxt = !src_a_ok || !reg_valid_r[in_ch.src_a_index[IDX_W-1:0]];
  assign zero_b_nxt = !src_b_ok || !reg_valid_r[in_ch.src_b_index[IDX_W-1:0]];

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (exe_fire && exe_we) begin
      regs[s1_dest_r[IDX_W-1:0]] <= exe_val;
    end
    if (in_fire) begin
      s1_rdata_a_r <= regs[in_ch.src_a_index[IDX_W-1:0]];
      s1_rdata_b_r <= regs[in_ch.src_b_index[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_valid_r <= '0;
      pc_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (exe_fire && exe_we) begin
        reg_valid_r[s1_dest_r[IDX_W-1:0]] <= 1'b1;
      end
      if (exe_fire) begin
        pc_r <= pc_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (exe_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (exe_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= in_ch.mode;
      s1_dest_r   <= in_ch.dest_index;
      s1_imm_r    <= in_ch.immediate;
      s1_zero_a_r <= zero_a_nxt;
      s1_zero_b_r <= zero_b_nxt;
      s1_fwd_a_r  <= fwd_a_nxt;
      s1_fwd_b_r  <= fwd_b_nxt;
    end
  end

  // Result stage payload and forwarding value.
  always_ff @(posedge clk) begin
    if (exe_fire) begin
      wb_val_r    <= exe_val;
      out_we_r    <= exe_we;
      out_idx_r   <= exe_we ? s1_dest_r : '0;
      out_val_r   <= exe_we ? exe_val : '0;
      out_taken_r <= exe_cond;
      out_pc_r    <= pc_nxt;
    end
  end

  // Operand selection: a forwarded write wins over the stored value.
  always_comb begin
    if (s1_fwd_a_r) begin
      opa = wb_val_r;
    end else if (s1_zero_a_r) begin
      opa = '0;
    end else begin
      opa = s1_rdata_a_r;
    end
    if (s1_fwd_b_r) begin
      opb = wb_val_r;
    end else if (s1_zero_b_r) begin
      opb = '0;
    end else begin
      opb = s1_rdata_b_r;
    end
  end

  assign shamt_b   = opb[SHAMT_W-1:0];
  assign shamt_i   = s1_imm_r[SHAMT_W-1:0];
  assign upper_imm = s1_imm_r << UPPER_SHIFT;
  assign lt_s_ab   = $signed(opa) < $signed(opb);
  assign lt_u_ab   = opa < opb;

  // Execute: ALU result and branch condition.
  always_comb begin
    exe_val  = '0;
    exe_alu  = 1'b1;
    exe_cond = 1'b0;
    unique case (mode_t'(s1_mode_r))
      MODE_ADD:   exe_val = opa + opb;
      MODE_SUB:   exe_val = opa - opb;
      MODE_SLL:   exe_val = opa << shamt_b;
      MODE_SLT:   exe_val = XLEN'(lt_s_ab);
      MODE_SLTU:  exe_val = XLEN'(lt_u_ab);
      MODE_XOR:   exe_val = opa ^ opb;
      MODE_SRL:   exe_val = opa >> shamt_b;
      MODE_SRA:   exe_val = word_t'($signed(opa) >>> shamt_b);
      MODE_OR:    exe_val = opa | opb;
      MODE_AND:   exe_val = opa & opb;
      MODE_ADDI:  exe_val = opa + s1_imm_r;
      MODE_SLTI:  exe_val = XLEN'($signed(opa) < $signed(s1_imm_r));
      MODE_SLTIU: exe_val = XLEN'(opa < s1_imm_r);
      MODE_XORI:  exe_val = opa ^ s1_imm_r;
      MODE_ORI:   exe_val = opa | s1_imm_r;
      MODE_ANDI:  exe_val = opa & s1_imm_r;
      MODE_SLLI:  exe_val = opa << shamt_i;
      MODE_SRLI:  exe_val = opa >> shamt_i;
      MODE_SRAI:  exe_val = word_t'($signed(opa) >>> shamt_i);
      MODE_LUI:   exe_val = upper_imm;
      MODE_AUIPC: exe_val = pc_r + upper_imm;
      MODE_BEQ: begin
        exe_alu  = 1'b0;
        exe_cond = (opa == opb);
      end
      MODE_BNE: begin
        exe_alu  = 1'b0;
        exe_cond = (opa != opb);
      end
      MODE_BLT: begin
        exe_alu  = 1'b0;
        exe_cond = lt_s_ab;
      end
      MODE_BGE: begin
        exe_alu  = 1'b0;
        exe_cond = !lt_s_ab;
      end
      MODE_BLTU: begin
        exe_alu  = 1'b0;
        exe_cond = lt_u_ab;
      end
      MODE_BGEU: begin
        exe_alu  = 1'b0;
        exe_cond = !lt_u_ab;
      end
      default: begin
        // Unused operation codes write no register and do not branch.
        exe_alu  = 1'b0;
        exe_cond = 1'b0;
      end
    endcase
  end

  // Writes to register zero or past the end of the register file are dropped.
  assign exe_we = exe_alu && (s1_dest_r != '0)
                  && ({1'b0, s1_dest_r} < (REG_IDX_W+1)'(NUM_REGS));
  assign pc_nxt = exe_cond ? (pc_r + s1_imm_r) : pc_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.write_index  = out_idx_r;
  assign out_ch.write_value  = out_val_r;
  assign out_ch.branch_taken = out_taken_r;
  assign out_ch.next_pc      = out_pc_r;

endmodule
